@@ design/bsl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bsl_pkg
// Shared constants, types and CRC helpers of the bucketed sample logger.
// ----------------------------------------------------------------------------
package bsl_pkg;

    // Field widths
    localparam int REQ_W   = 2;
    localparam int UTC_W   = 32;
    localparam int VAL_W   = 32;
    localparam int MS_W    = 42;
    localparam int CRC_W   = 32;
    localparam int CNT_W   = 13;
    localparam int DROP_W  = 32;
    localparam int KIND_W  = 2;

    // Bucket lengths and store size
    localparam int SPEED_BUCKET_S  = 60;
    localparam int CHARGE_BUCKET_S = 300;
    localparam int MAX_RECORDS     = 5461;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PURGE   = 2'd2;

    // Record signal codes
    localparam logic [KIND_W-1:0] KIND_CHARGE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SPEED  = 2'd2;

    // Misc constants
    localparam logic [UTC_W-1:0] MIN_UTC      = 32'd1700000000;
    localparam logic [VAL_W-1:0] SPEED_THRESH = 32'h3F80_0000;
    localparam logic [VAL_W-1:0] FLOAT_INF    = 32'h7F80_0000;
    localparam logic [9:0]       MS_PER_S     = 10'd1000;
    localparam logic [31:0]      REC_MAGIC    = 32'h4D4F_5443;
    localparam logic [7:0]       REC_VERSION  = 8'd1;
    localparam logic [CRC_W-1:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT     = 32'hFFFF_FFFF;
    localparam int               REC_BITS     = 160;

    // Reciprocals for the bucket quotients: q = (t * RECIP) >> SHIFT
    localparam int RECIP_W   = UTC_W + 1;
    localparam int PROD_W    = UTC_W + RECIP_W;
    localparam int SPD_SHIFT = UTC_W + $clog2(SPEED_BUCKET_S);
    localparam int CHG_SHIFT = UTC_W + $clog2(CHARGE_BUCKET_S);
    localparam logic [RECIP_W-1:0] SPD_RECIP = RECIP_W'(((64'd1 << SPD_SHIFT)
        + 64'(SPEED_BUCKET_S) - 64'd1) / 64'(SPEED_BUCKET_S));
    localparam logic [RECIP_W-1:0] CHG_RECIP = RECIP_W'(((64'd1 << CHG_SHIFT)
        + 64'(CHARGE_BUCKET_S) - 64'd1) / 64'(CHARGE_BUCKET_S));

    // Raw input item (all fields, the request code included)
    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [UTC_W-1:0] utc_seconds;
        logic             display_valid;
        logic [VAL_W-1:0] speed_bits;
        logic [VAL_W-1:0] charge_bits;
        logic             charging;
        logic [CNT_W-1:0] release_count;
    } t_in;

    // Prepared item handed to the decision stage
    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             utc_ok;
        logic             display_valid;
        logic [VAL_W-1:0] speed_bits;
        logic [VAL_W-1:0] charge_bits;
        logic             charging;
        logic [CNT_W-1:0] release_count;
        logic [MS_W-1:0]  stamp_ms;
        logic [UTC_W-1:0] q_speed;
        logic [UTC_W-1:0] q_charge;
        logic [CRC_W-1:0] crc_ms_part;
        logic [CRC_W-1:0] crc_spd_part;
        logic [CRC_W-1:0] crc_soc_part;
    } t_item;

    // One result record
    typedef struct packed {
        logic [KIND_W-1:0] signal_kind;
        logic [MS_W-1:0]   stamp_ms;
        logic [VAL_W-1:0]  value_bits;
        logic [CRC_W-1:0]  record_crc;
        logic              stored;
        logic [CNT_W-1:0]  records_held;
        logic [DROP_W-1:0] drops_total;
        logic              last;
    } t_result;

    // Write strobes from the decision stage into the result queue
    typedef struct packed {
        logic wr0;
        logic wr1;
    } t_push;

    // Result queue status
    typedef struct packed {
        logic room;
        logic empty;
    } t_fifo_stat;

    typedef logic [MS_W-1:0][CRC_W-1:0]  t_ms_cols;
    typedef logic [VAL_W-1:0][CRC_W-1:0] t_val_cols;

    // Bitwise reflected CRC over a whole record, LSB of byte 0 first
    function automatic logic [CRC_W-1:0] crc_raw(input logic [CRC_W-1:0] init,
                                                 input logic [REC_BITS-1:0] msg);
        logic [CRC_W-1:0] c;
        c = init;
        for (int i = 0; i < REC_BITS; i++) begin
            c = (c >> 1) ^ ((c[0] ^ msg[i]) ? CRC_POLY : '0);
        end
        return c;
    endfunction

    // Record bytes, little endian: magic, version, kind, pad, ms, pad, value
    function automatic logic [REC_BITS-1:0] rec_msg(input logic [KIND_W-1:0] kind,
                                                    input logic [MS_W-1:0] ms,
                                                    input logic [VAL_W-1:0] val);
        return {val, 22'd0, ms, 16'd0, 6'd0, kind, REC_VERSION, REC_MAGIC};
    endfunction

    // Contribution of each stamp bit alone (zero init, no final inversion,
    // magic and version bytes cancelled out)
    function automatic t_ms_cols crc_ms_cols();
        t_ms_cols cols;
        for (int j = 0; j < MS_W; j++) begin
            cols[j] = crc_raw('0, rec_msg('0, MS_W'(1) << j, '0)
                                  ^ rec_msg('0, '0, '0));
        end
        return cols;
    endfunction

    // Contribution of each value bit alone
    function automatic t_val_cols crc_val_cols();
        t_val_cols cols;
        for (int j = 0; j < VAL_W; j++) begin
            cols[j] = crc_raw('0, rec_msg('0, '0, VAL_W'(1) << j)
                                  ^ rec_msg('0, '0, '0));
        end
        return cols;
    endfunction

    localparam t_ms_cols  CRC_MS_COLS  = crc_ms_cols();
    localparam t_val_cols CRC_VAL_COLS = crc_val_cols();

    // Final CRC of a record whose stamp and value are zero
    localparam logic [CRC_W-1:0] CRC_BASE_SPEED  =
        ~crc_raw(CRC_INIT, rec_msg(KIND_SPEED, '0, '0));
    localparam logic [CRC_W-1:0] CRC_BASE_CHARGE =
        ~crc_raw(CRC_INIT, rec_msg(KIND_CHARGE, '0, '0));

    // XOR of the stamp columns selected by the stamp bits
    function automatic logic [CRC_W-1:0] crc_ms_part(input logic [MS_W-1:0] ms);
        logic [CRC_W-1:0] p;
        p = '0;
        for (int j = 0; j < MS_W; j++) begin
            p = p ^ (ms[j] ? CRC_MS_COLS[j] : '0);
        end
        return p;
    endfunction

    // XOR of the value columns selected by the value bits
    function automatic logic [CRC_W-1:0] crc_val_part(input logic [VAL_W-1:0] val);
        logic [CRC_W-1:0] p;
        p = '0;
        for (int j = 0; j < VAL_W; j++) begin
            p = p ^ (val[j] ? CRC_VAL_COLS[j] : '0);
        end
        return p;
    endfunction

endpackage
`default_nettype wire

@@ design/bucketed_sample_logger.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bucketed_sample_logger
// Logs speed and state-of-charge records per time bucket with record CRC.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries requests (tuser = request code): sample ticks, release of
//   acknowledged records and purge of the store. m_axis delivers the records
//   a tick produces, zero, one or two of them, speed first; tlast marks the
//   final record of a tick. Release and purge produce no transfer.
//   The cfg channel writes the cache enable bit and is always ready; the
//   user must write it only while the block is idle, which the block
//   itself does not enforce. A tick passes the input register, multiplier
//   stage and CRC stage, then the result queue, before its records appear
//   on m_axis. One request per cycle while a tick yields at most one record
//   and the receiver takes every record; ticks yielding two records are
//   bound by the single output port.
//   Reset clears the enable, bucket marks, record and drop counts and the
//   queue. When the receiver stalls, the four-entry result queue fills and
//   s_axis_tready drops once fewer than two entries are free; nothing is
//   lost.
// ----------------------------------------------------------------------------
module bucketed_sample_logger (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // cfg write: bit 0 cache_enable
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic          i_cfg_data,
    // tdata: utc_seconds[31:0], display_valid[32], speed_bits[64:33],
    //        charge_bits[96:65], charging[97], release_count[110:98], pad[111]
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [111:0]  s_axis_tdata,
    // tuser: req_type[1:0]
    input  wire logic [1:0]    s_axis_tuser,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // tdata: stamp_ms[41:0], value_bits[73:42], record_crc[105:74],
    //        stored[106], records_held[119:107], drops_total[151:120]
    output logic [151:0]       m_axis_tdata,
    // tuser: signal_kind[1:0]
    output logic [1:0]         m_axis_tuser,
    output logic               m_axis_tlast
);
    import bsl_pkg::*;

    t_in        in_item;
    t_item      c_item;
    logic       c_valid, adv, fire;
    t_push      push;
    t_result    res0, res1, head;
    t_fifo_stat stat;

    // Unpack the input transfer
    always_comb begin
        in_item.req_type      = s_axis_tuser;
        in_item.utc_seconds   = s_axis_tdata[31:0];
        in_item.display_valid = s_axis_tdata[32];
        in_item.speed_bits    = s_axis_tdata[64:33];
        in_item.charge_bits   = s_axis_tdata[96:65];
        in_item.charging      = s_axis_tdata[97];
        in_item.release_count = s_axis_tdata[110:98];
    end

    // Move the pipeline unless the last stage waits for queue room
    assign adv           = !c_valid || stat.room;
    assign fire          = c_valid && stat.room;
    assign s_axis_tready = adv;
    assign o_cfg_ready   = 1'b1;

    bsl_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_in_valid (s_axis_tvalid),
        .i_in       (in_item),
        .o_valid    (c_valid),
        .o_item     (c_item)
    );

    bsl_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_item      (c_item),
        .o_push      (push),
        .o_res0      (res0),
        .o_res1      (res1)
    );

    bsl_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res0  (res0),
        .i_res1  (res1),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_res   (head),
        .o_stat  (stat)
    );

    // Pack the output transfer
    assign m_axis_tdata = {head.drops_total, head.records_held, head.stored,
                           head.record_crc, head.value_bits, head.stamp_ms};
    assign m_axis_tuser = head.signal_kind;
    assign m_axis_tlast = head.last;

    // Held count never exceeds the store size
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[119:107] <= CNT_W'(MAX_RECORDS)))
        else $error("records_held above store size");

    // A dropped record is only reported with a full store
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[106])
            |-> (m_axis_tdata[119:107] == CNT_W'(MAX_RECORDS)))
        else $error("record dropped while store not full");

    // A charge record always closes its tick
    a_charge_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_CHARGE)) |-> m_axis_tlast)
        else $error("charge record not marked last");

    // Queue writes happen only when room was granted
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.wr0 |-> (stat.room && c_valid))
        else $error("result written without queue room");

endmodule
`default_nettype wire

@@ design/bsl_prep.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bsl_prep
// Input register, stamp and bucket multipliers, CRC partial terms.
// ----------------------------------------------------------------------------
module bsl_prep (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire logic          i_in_valid,
    input  wire bsl_pkg::t_in  i_in,
    output logic               o_valid,
    output bsl_pkg::t_item     o_item
);
    import bsl_pkg::*;

    logic  r_a_valid, r_b_valid, r_c_valid;
    t_in   r_a;
    t_item r_b, r_c;
    t_item n_b, n_c;

    logic [PROD_W-1:0] spd_prod, chg_prod;

    // Stamp, bucket quotients and value CRC terms from the input register
    always_comb begin
        spd_prod         = PROD_W'(r_a.utc_seconds) * PROD_W'(SPD_RECIP);
        chg_prod         = PROD_W'(r_a.utc_seconds) * PROD_W'(CHG_RECIP);
        n_b.req_type      = r_a.req_type;
        n_b.utc_ok        = (r_a.utc_seconds >= MIN_UTC);
        n_b.display_valid = r_a.display_valid;
        n_b.speed_bits    = r_a.speed_bits;
        n_b.charge_bits   = r_a.charge_bits;
        n_b.charging      = r_a.charging;
        n_b.release_count = r_a.release_count;
        n_b.stamp_ms      = MS_W'(r_a.utc_seconds) * MS_W'(MS_PER_S);
        n_b.q_speed       = UTC_W'(spd_prod >> SPD_SHIFT);
        n_b.q_charge      = UTC_W'(chg_prod >> CHG_SHIFT);
        n_b.crc_ms_part   = '0;
        n_b.crc_spd_part  = crc_val_part(r_a.speed_bits);
        n_b.crc_soc_part  = crc_val_part(r_a.charge_bits);
    end

    // Stamp CRC term from the registered stamp
    always_comb begin
        n_c             = r_b;
        n_c.crc_ms_part = crc_ms_part(r_b.stamp_ms);
    end

    // Advance all three stages together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_adv) begin
            r_a_valid <= i_in_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a <= i_in;
            r_b <= n_b;
            r_c <= n_c;
        end
    end

    assign o_valid = r_c_valid;
    assign o_item  = r_c;

endmodule
`default_nettype wire

@@ design/bsl_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bsl_core
// Logging decision, record count, drop count and bucket marks.
// ----------------------------------------------------------------------------
module bsl_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_valid,
    input  wire logic            i_cfg_data,
    input  wire logic            i_fire,
    input  wire bsl_pkg::t_item  i_item,
    output bsl_pkg::t_push       o_push,
    output bsl_pkg::t_result     o_res0,
    output bsl_pkg::t_result     o_res1
);
    import bsl_pkg::*;

    logic              r_cache_enable;
    logic [UTC_W-1:0]  r_seen_speed, n_seen_speed;
    logic [UTC_W-1:0]  r_seen_charge, n_seen_charge;
    logic              r_was_moving, n_was_moving;
    logic [CNT_W-1:0]  r_record_total, n_record_total;
    logic [DROP_W-1:0] r_drop_total, n_drop_total;

    logic              moving, tick_on;
    logic              want_spd, want_stop, emit_spd, emit_chg;
    logic              ok1, ok2;
    logic [CNT_W-1:0]  held1, held_a, held2;
    logic [DROP_W-1:0] drop1, drop_a, drop2;
    t_result           spd_res, chg_res;

    // Decide which records this item produces and update the counters
    always_comb begin
        n_seen_speed   = r_seen_speed;
        n_seen_charge  = r_seen_charge;
        n_was_moving   = r_was_moving;
        n_record_total = r_record_total;
        n_drop_total   = r_drop_total;
        o_push         = '0;
        o_res0         = '0;
        o_res1         = '0;

        moving    = (i_item.speed_bits > SPEED_THRESH) && (i_item.speed_bits <= FLOAT_INF);
        tick_on   = r_cache_enable && i_item.display_valid && i_item.utc_ok;
        want_spd  = moving && (i_item.q_speed != r_seen_speed);
        want_stop = !moving && r_was_moving;
        emit_spd  = want_spd || want_stop;
        emit_chg  = (moving || i_item.charging) && (i_item.q_charge != r_seen_charge);

        // Speed record goes first
        ok1    = (r_record_total < CNT_W'(MAX_RECORDS));
        held1  = ok1 ? r_record_total + 1'b1 : r_record_total;
        drop1  = ok1 ? r_drop_total : r_drop_total + 1'b1;
        held_a = emit_spd ? held1 : r_record_total;
        drop_a = emit_spd ? drop1 : r_drop_total;

        ok2    = (held_a < CNT_W'(MAX_RECORDS));
        held2  = ok2 ? held_a + 1'b1 : held_a;
        drop2  = ok2 ? drop_a : drop_a + 1'b1;

        spd_res.signal_kind  = KIND_SPEED;
        spd_res.stamp_ms     = i_item.stamp_ms;
        spd_res.value_bits   = want_spd ? i_item.speed_bits : '0;
        spd_res.record_crc   = CRC_BASE_SPEED ^ i_item.crc_ms_part
                               ^ (want_spd ? i_item.crc_spd_part : '0);
        spd_res.stored       = ok1;
        spd_res.records_held = held1;
        spd_res.drops_total  = drop1;
        spd_res.last         = !emit_chg;

        chg_res.signal_kind  = KIND_CHARGE;
        chg_res.stamp_ms     = i_item.stamp_ms;
        chg_res.value_bits   = i_item.charge_bits;
        chg_res.record_crc   = CRC_BASE_CHARGE ^ i_item.crc_ms_part ^ i_item.crc_soc_part;
        chg_res.stored       = ok2;
        chg_res.records_held = held2;
        chg_res.drops_total  = drop2;
        chg_res.last         = 1'b1;

        if (i_fire) begin
            case (i_item.req_type)
                REQ_TICK: begin
                    if (tick_on) begin
                        o_push.wr0     = emit_spd || emit_chg;
                        o_push.wr1     = emit_spd && emit_chg;
                        o_res0         = emit_spd ? spd_res : chg_res;
                        o_res1         = chg_res;
                        n_was_moving   = moving;
                        n_record_total = emit_chg ? held2 : held_a;
                        n_drop_total   = emit_chg ? drop2 : drop_a;
                        if (want_spd && ok1) begin
                            n_seen_speed = i_item.q_speed;
                        end
                        if (emit_chg && ok2) begin
                            n_seen_charge = i_item.q_charge;
                        end
                    end
                end
                REQ_RELEASE: begin
                    n_record_total = (i_item.release_count >= r_record_total) ? '0
                                     : r_record_total - i_item.release_count;
                end
                REQ_PURGE: begin
                    n_record_total = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Hold state and the enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_enable <= 1'b0;
            r_seen_speed   <= '0;
            r_seen_charge  <= '0;
            r_was_moving   <= 1'b0;
            r_record_total <= '0;
            r_drop_total   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_cache_enable <= i_cfg_data;
            end
            r_seen_speed   <= n_seen_speed;
            r_seen_charge  <= n_seen_charge;
            r_was_moving   <= n_was_moving;
            r_record_total <= n_record_total;
            r_drop_total   <= n_drop_total;
        end
    end

endmodule
`default_nettype wire

@@ design/bsl_out_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bsl_out_fifo
// Small result queue: up to two writes per cycle, one read per cycle.
// ----------------------------------------------------------------------------
module bsl_out_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bsl_pkg::t_push    i_push,
    input  wire bsl_pkg::t_result  i_res0,
    input  wire bsl_pkg::t_result  i_res1,
    input  wire logic              i_ready,
    output logic                   o_valid,
    output bsl_pkg::t_result       o_res,
    output bsl_pkg::t_fifo_stat    o_stat
);
    import bsl_pkg::*;

    localparam int DEPTH      = 4;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int FIFO_CNT_W = $clog2(DEPTH + 1);

    t_result               r_mem [DEPTH];
    logic [PTR_W-1:0]      r_wp, n_wp, r_rp, n_rp;
    logic [FIFO_CNT_W-1:0] r_count, n_count;
    logic                  rd;

    // Pointer and occupancy update
    always_comb begin
        rd      = o_valid && i_ready;
        n_wp    = r_wp + PTR_W'(i_push.wr0) + PTR_W'(i_push.wr1);
        n_rp    = r_rp + PTR_W'(rd);
        n_count = r_count + FIFO_CNT_W'(i_push.wr0) + FIFO_CNT_W'(i_push.wr1)
                  - FIFO_CNT_W'(rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // Write one or two results
    always_ff @(posedge i_clk) begin
        if (i_push.wr0) begin
            r_mem[r_wp] <= i_res0;
        end
        if (i_push.wr1) begin
            r_mem[r_wp + PTR_W'(1)] <= i_res1;
        end
    end

    assign o_valid      = (r_count != '0);
    assign o_res        = r_mem[r_rp];
    assign o_stat.room  = (r_count <= FIFO_CNT_W'(DEPTH - 2));
    assign o_stat.empty = !o_valid;

endmodule
`default_nettype wire

@@ tb/tb_bucketed_sample_logger.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bucketed_sample_logger
// Self-checking bench: a directed table of ticks and store requests, then
// driving, charging, noise and housekeeping episodes.
// Every record is checked against an in-bench predictor of buckets, counts
// and record CRC, with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module tb_bucketed_sample_logger;
    import bsl_pkg::*;

    localparam int NO_CFG          = -1;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RANDOM_ITEMS    = 850;
    localparam int HOLD_OFF_AFTER  = 200;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int MAX_REPORTS     = 200;
    localparam int RUN_LIMIT_NS    = 2000000;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam logic [31:0] T0      = MIN_UTC;
    localparam logic [31:0] SPD_50  = 32'h4248_0000;
    localparam logic [31:0] SPD_10  = 32'h4120_0000;
    localparam logic [31:0] SPD_NEG = 32'hC248_0000;
    localparam logic [31:0] NAN_Q   = 32'h7FC0_0000;
    localparam logic [31:0] SOC_80  = 32'h42A0_0000;

    // One request as seen on the input stream
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [31:0]      utc;
        logic             dv;
        logic [31:0]      spd;
        logic [31:0]      soc;
        logic             chg;
        logic [CNT_W-1:0] rel;
    } t_sample_req;

    // Directed row: optional enable write first, then the request
    typedef struct packed {
        int          cfg;
        t_sample_req item;
        int          n_rec;
    } t_dir_row;

    typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_TOGGLE} t_rx_mode;
    typedef enum int {EP_DRIVE, EP_CHARGE, EP_NOISE, EP_HOUSEKEEP} t_episode;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic           i_cfg_data;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [111:0]   s_axis_tdata;
    logic [1:0]     s_axis_tuser;
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [151:0]   m_axis_tdata;
    logic [1:0]     m_axis_tuser;
    logic           m_axis_tlast;

    // Predictor state
    logic        cache_on;
    logic [31:0] spd_mark;
    logic [31:0] soc_mark;
    logic        in_motion;
    int          held_cnt;
    logic [31:0] drop_cnt;
    t_result     pending_records[$];

    int fail_count;
    int records_seen;
    int burst_left;

    t_dir_row directed_rows [24] = '{
        '{NO_CFG, '{REQ_TICK, T0 + 32'd100, 1'b1, SPD_50, SOC_80, 1'b1, 13'd0}, 0},
        '{NO_CFG, '{REQ_RELEASE, 32'd0, 1'b0, 32'd0, 32'd0, 1'b0, 13'd3}, 0},
        '{NO_CFG, '{REQ_PURGE, 32'd0, 1'b0, 32'd0, 32'd0, 1'b0, 13'd0}, 0},
        '{1, '{REQ_TICK, T0 - 32'd1, 1'b1, SPD_50, SOC_80, 1'b1, 13'd0}, 0},
        '{NO_CFG, '{REQ_TICK, T0, 1'b0, SPD_50, SOC_80, 1'b1, 13'd0}, 0},
        '{NO_CFG, '{REQ_TICK, T0, 1'b1, SPEED_THRESH + 32'd1, SOC_80, 1'b0, 13'd0}, 2},
        '{NO_CFG, '{REQ_TICK, T0 + 32'd1, 1'b1, SPD_50, SOC_80, 1'b1, 13'd0}, 0},
        '{NO_CFG, '{REQ_TICK, T0 + 32'd45, 1'b1, FLOAT_INF, SOC_80, 1'b0, 13'd0}, 1},
        '{NO_CFG, '{REQ_TICK, T0 + 32'd50, 1'b1, SPEED_THRESH, SOC_80, 1'b0, 13'd0}, 1},
        '{NO_CFG, '{REQ_TICK, T0 + 32'd55, 1'b1, NAN_Q, SOC_80, 1'b1, 13'd0}, 0},
        '{NO_CFG, '{REQ_TICK, T0 + 32'd130, 1'b1, SPD_NEG, 32'd0, 1'b1, 13'd0}, 1},
        '{NO_CFG, '{REQ_TICK, T0 + 32'd200, 1'b1, FLOAT_INF + 32'd1, SOC_80, 1'b0,
                    13'd0}, 0},
        '{NO_CFG, '{REQ_TICK, 32'hFFFF_FFFF, 1'b1, 32'h7F7F_FFFF, 32'hFFFF_FFFF, 1'b1,
                    13'd0}, 2},
        '{NO_CFG, '{REQ_TICK, 32'hFFFF_FFFF, 1'b1, 32'd0, 32'd0, 1'b0, 13'd0}, 1},
        '{NO_CFG, '{REQ_UNUSED, T0 + 32'd300, 1'b1, SPD_50, SOC_80, 1'b1, 13'd0}, 0},
        '{NO_CFG, '{REQ_RELEASE, 32'd0, 1'b0, 32'd0, 32'd0, 1'b0, 13'(MAX_RECORDS)}, 0},
        '{NO_CFG, '{REQ_TICK, T0 + 32'd400, 1'b1, SPD_10, SOC_80, 1'b0, 13'd0}, 2},
        '{NO_CFG, '{REQ_RELEASE, 32'd0, 1'b0, 32'd0, 32'd0, 1'b0, 13'd1}, 0},
        '{NO_CFG, '{REQ_PURGE, 32'd0, 1'b0, 32'd0, 32'd0, 1'b0, 13'd0}, 0},
        '{NO_CFG, '{REQ_RELEASE, 32'd0, 1'b0, 32'd0, 32'd0, 1'b0, 13'd0}, 0},
        '{0, '{REQ_TICK, T0 + 32'd1000, 1'b1, SPD_50, SOC_80, 1'b0, 13'd0}, 0},
        '{1, '{REQ_TICK, T0 + 32'd1000, 1'b1, SPD_50, SOC_80, 1'b0, 13'd0}, 2},
        '{NO_CFG, '{REQ_TICK, T0 + 32'd1001, 1'b0, 32'd0, SOC_80, 1'b0, 13'd0}, 0},
        '{NO_CFG, '{REQ_TICK, T0 + 32'd1002, 1'b1, 32'd0, SOC_80, 1'b0, 13'd0}, 1}
    };

    bucketed_sample_logger dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop for a hung run
    initial begin
        #(RUN_LIMIT_NS);
        $error("timeout: %0d records still outstanding", pending_records.size());
        $display("bucketed_sample_logger regression: fail");
        $finish;
    end

    // Reflected CRC-32 over the 20 record bytes, byte 0 first
    function automatic logic [31:0] record_crc32(input logic [KIND_W-1:0] kind,
                                                 input logic [MS_W-1:0] ms,
                                                 input logic [31:0] val);
        logic [159:0] bytes_le;
        logic [31:0]  c;
        bytes_le = {val, 22'd0, ms, 16'd0, 6'd0, kind, REC_VERSION, REC_MAGIC};
        c = CRC_INIT;
        for (int i = 0; i < 20; i++) begin
            c = c ^ {24'd0, bytes_le[8*i +: 8]};
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
        end
        return ~c;
    endfunction

    // Append to the store or count a drop, and build the record
    function automatic t_result new_record(input logic [KIND_W-1:0] kind,
                                           input logic [MS_W-1:0] ms,
                                           input logic [31:0] val);
        t_result rec;
        rec.stored = (held_cnt < MAX_RECORDS);
        if (rec.stored) begin
            held_cnt++;
        end else begin
            drop_cnt++;
        end
        rec.signal_kind  = kind;
        rec.stamp_ms     = ms;
        rec.value_bits   = val;
        rec.record_crc   = record_crc32(kind, ms, val);
        rec.records_held = CNT_W'(held_cnt);
        rec.drops_total  = drop_cnt;
        rec.last         = 1'b0;
        return rec;
    endfunction

    // Advance the logger state by one request and queue the records it yields
    function automatic int predict_records(input t_sample_req r);
        t_result         recs [2];
        int              n;
        logic [MS_W-1:0] ms;
        logic [31:0]     sb;
        logic [31:0]     cb;
        logic            moving;
        n = 0;
        case (r.req)
            REQ_RELEASE: begin
                held_cnt = (int'(r.rel) >= held_cnt) ? 0 : held_cnt - int'(r.rel);
            end
            REQ_PURGE: begin
                held_cnt = 0;
            end
            REQ_TICK: begin
                if (cache_on && r.dv && r.utc >= MIN_UTC) begin
                    ms     = MS_W'(r.utc) * MS_W'(1000);
                    moving = (r.spd > SPEED_THRESH) && (r.spd <= FLOAT_INF);
                    sb     = r.utc - r.utc % 32'(SPEED_BUCKET_S);
                    if (moving && sb != spd_mark) begin
                        recs[n] = new_record(KIND_SPEED, ms, r.spd);
                        if (recs[n].stored) spd_mark = sb;
                        n++;
                    end else if (!moving && in_motion) begin
                        // stop record: no bucket mark, drops still counted
                        recs[n] = new_record(KIND_SPEED, ms, 32'd0);
                        n++;
                    end
                    in_motion = moving;
                    cb = r.utc - r.utc % 32'(CHARGE_BUCKET_S);
                    if ((moving || r.chg) && cb != soc_mark) begin
                        recs[n] = new_record(KIND_CHARGE, ms, r.soc);
                        if (recs[n].stored) soc_mark = cb;
                        n++;
                    end
                end
            end
            default: begin
            end
        endcase
        if (n > 0) recs[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) pending_records.push_back(recs[i]);
        return n;
    endfunction

    // Flag one field; the log is capped so a broken build stays readable
    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            end
        end
    endfunction

    // Record checker
    always @(posedge i_clk) begin : record_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.signal_kind  = m_axis_tuser;
            got.stamp_ms     = m_axis_tdata[41:0];
            got.value_bits   = m_axis_tdata[73:42];
            got.record_crc   = m_axis_tdata[105:74];
            got.stored       = m_axis_tdata[106];
            got.records_held = m_axis_tdata[119:107];
            got.drops_total  = m_axis_tdata[151:120];
            got.last         = m_axis_tlast;
            records_seen++;
            if (pending_records.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $error("record with nothing expected: kind %0d stamp %0d",
                           got.signal_kind, got.stamp_ms);
                end
            end else begin
                want = pending_records.pop_front();
                check_field("signal_kind", want.signal_kind, got.signal_kind);
                check_field("stamp_ms", want.stamp_ms, got.stamp_ms);
                check_field("value_bits", want.value_bits, got.value_bits);
                check_field("record_crc", want.record_crc, got.record_crc);
                check_field("stored", want.stored, got.stored);
                check_field("records_held", want.records_held, got.records_held);
                check_field("drops_total", want.drops_total, got.drops_total);
                check_field("last", want.last, got.last);
            end
        end
    end

    // Output side: stall in segments of varying shape, one long hold-off
    initial begin : record_sink
        t_rx_mode mode;
        int       seg_left;
        int       hold_left;
        logic     hold_done;
        m_axis_tready = 1'b0;
        mode      = RX_FREE;
        seg_left  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && records_seen >= HOLD_OFF_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode     = t_rx_mode'($urandom_range(0, 3));
                    seg_left = $urandom_range(8, 60);
                end
                seg_left--;
                case (mode)
                    RX_FREE:   m_axis_tready <= 1'b1;
                    RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_axis_tready <= seg_left[0];
                endcase
            end
        end
    end

    // Offer one request in bursts with random gaps, predict on transfer
    task automatic push_request(input t_sample_req r, output int n_rec);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, r.rel, r.chg, r.soc, r.spd, r.dv, r.utc};
        s_axis_tuser  <= r.req;
        do @(posedge i_clk); while (!s_axis_tready);
        n_rec = predict_records(r);
    endtask

    // Stop offering and wait until the block has nothing left in flight
    task automatic drain_block();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cache_enable(input logic en);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= en;
        do @(posedge i_clk); while (!o_cfg_ready);
        cache_on = en;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] moving_speed();
        case ($urandom_range(0, 9))
            0:       return FLOAT_INF;
            1:       return SPEED_THRESH + 32'd1;
            default: return $urandom_range(SPEED_THRESH + 32'd1, FLOAT_INF - 32'd1);
        endcase
    endfunction

    function automatic logic [31:0] still_speed();
        case ($urandom_range(0, 4))
            0:       return 32'd0;
            1:       return SPEED_THRESH;
            2:       return $urandom_range(0, SPEED_THRESH);
            3:       return $urandom | 32'h8000_0000;
            default: return $urandom_range(FLOAT_INF + 32'd1, 32'h7FFF_FFFF);
        endcase
    endfunction

    function automatic t_sample_req tick_at(input logic [31:0] utc, input logic [31:0] spd,
                                            input logic chg);
        t_sample_req r;
        r.req = REQ_TICK;
        r.utc = utc;
        r.dv  = ($urandom_range(0, 19) != 0);
        r.spd = spd;
        r.soc = $urandom;
        r.chg = chg;
        r.rel = CNT_W'($urandom_range(0, MAX_RECORDS));
        return r;
    endfunction

    function automatic t_sample_req noise_item(input logic [31:0] clock_s);
        t_sample_req r;
        r = tick_at(clock_s, $urandom, 1'($urandom_range(0, 1)));
        r.req = REQ_W'($urandom_range(0, 3));
        r.dv  = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0:       r.utc = $urandom;
            1:       r.utc = MIN_UTC - 32'd1 - $urandom_range(0, 1000);
            2:       r.utc = 32'hFFFF_FFFF;
            default: r.utc = clock_s + $urandom_range(0, 600);
        endcase
        return r;
    endfunction

    // Stimulus
    initial begin : stimulus
        t_sample_req r;
        t_episode    ep;
        logic [31:0] clock_s;
        int          n;
        int          len;
        int          sent;

        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cache_on      = 1'b0;
        spd_mark      = '0;
        soc_mark      = '0;
        in_motion     = 1'b0;
        held_cnt      = 0;
        drop_cnt      = '0;
        fail_count    = 0;
        records_seen  = 0;
        burst_left    = 0;
        sent          = 0;
        clock_s       = T0 + 32'd5000;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].cfg != NO_CFG) begin
                drain_block();
                write_cache_enable(directed_rows[i].cfg[0]);
            end
            push_request(directed_rows[i].item, n);
            if (n != directed_rows[i].n_rec) begin
                fail_count++;
                $error("row %0d: record count expected %0d, predicted %0d",
                       i, directed_rows[i].n_rec, n);
            end
        end

        // Random episodes
        while (sent < RANDOM_ITEMS) begin
            if (cache_on && $urandom_range(0, 19) == 0) begin
                drain_block();
                write_cache_enable(1'b0);
            end else if (!cache_on) begin
                drain_block();
                write_cache_enable(1'b1);
            end

            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: ep = EP_DRIVE;
                5, 6:          ep = EP_CHARGE;
                7, 8:          ep = EP_NOISE;
                default:       ep = EP_HOUSEKEEP;
            endcase
            case (ep)
                EP_DRIVE: begin
                    len = $urandom_range(5, 30);
                    repeat (len) begin
                        clock_s = clock_s + $urandom_range(1, 90);
                        r = tick_at(clock_s, ($urandom_range(0, 7) == 0) ? still_speed()
                                                                       : moving_speed(),
                                    ($urandom_range(0, 9) == 0));
                        push_request(r, n);
                    end
                    sent += len;
                end
                EP_CHARGE: begin
                    len = $urandom_range(3, 15);
                    repeat (len) begin
                        clock_s = clock_s + $urandom_range(20, 400);
                        r = tick_at(clock_s, still_speed(), ($urandom_range(0, 7) != 0));
                        push_request(r, n);
                    end
                    sent += len;
                end
                EP_NOISE: begin
                    len = $urandom_range(2, 8);
                    repeat (len) push_request(noise_item(clock_s), n);
                    sent += len;
                end
                default: begin
                    r = tick_at(clock_s, 32'd0, 1'b0);
                    r.req = ($urandom_range(0, 3) == 0) ? REQ_PURGE : REQ_RELEASE;
                    r.rel = ($urandom_range(0, 1) == 0) ? CNT_W'($urandom_range(0, 8))
                                                        : CNT_W'($urandom_range(0, MAX_RECORDS));
                    push_request(r, n);
                    sent++;
                end
            endcase
        end

        drain_block();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("bucketed_sample_logger regression: pass");
        end else begin
            $display("bucketed_sample_logger regression: fail");
        end
        $finish;
    end

endmodule
